>>> rtl/lxc_pkg.sv
// ----------------------------------------------------------------------------
// lxc_pkg
// Shared widths, coefficients, codes and pipeline beat types for the
// two-channel lux calculator.
// ----------------------------------------------------------------------------
package lxc_pkg;

    localparam int CNT_W      = 16;
    localparam int SUM_W      = CNT_W + 1;
    localparam int PROD_W     = 24;
    localparam int CODE_W     = 3;
    localparam int SHIFT_W    = 3;
    localparam int HALF_W     = 4;
    localparam int DIV_W      = 7;
    localparam int COEF_W     = 16;
    localparam int NUM_W      = 32;
    localparam int LUX_W      = 29;
    localparam int DIGIT_W    = 2;
    localparam int TRIAL_W    = DIV_W + DIGIT_W;
    localparam int DIV_STEPS  = NUM_W / DIGIT_W;
    localparam int FRONT_DEPTH = 3;
    localparam int PIPE_DEPTH = FRONT_DEPTH + DIV_STEPS + 1;

    localparam logic [LUX_W-1:0] LUX_MAX = '1;

    // channel ratio thresholds, in hundredths
    localparam logic [6:0] RATIO_SCALE = 7'd100;
    localparam logic [6:0] RATIO_LOW   = 7'd45;
    localparam logic [6:0] RATIO_MID   = 7'd64;
    localparam logic [6:0] RATIO_HIGH  = 7'd85;

    // formula coefficients scaled by 10000
    localparam logic [COEF_W-1:0] COEF_LOW_A  = 16'd17743;
    localparam logic [COEF_W-1:0] COEF_LOW_B  = 16'd11059;
    localparam logic [COEF_W-1:0] COEF_MID_A  = 16'd42785;
    localparam logic [COEF_W-1:0] COEF_MID_B  = 16'd19548;
    localparam logic [COEF_W-1:0] COEF_HIGH_A = 16'd5926;
    localparam logic [COEF_W-1:0] COEF_HIGH_B = 16'd1185;

    // gain codes with special handling
    localparam logic [CODE_W-1:0] GAIN_BAD4 = 3'd4;
    localparam logic [CODE_W-1:0] GAIN_BAD5 = 3'd5;
    localparam logic [CODE_W-1:0] GAIN_X48  = 3'd6;
    localparam logic [CODE_W-1:0] GAIN_X96  = 3'd7;

    // configuration register indexes
    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_ITIME = 1'b1;

    typedef enum logic [1:0] {
        BAND_LOW,
        BAND_MID,
        BAND_HIGH,
        BAND_ZERO
    } band_t;

    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  ch0;
        logic [CNT_W-1:0]  ch1;
        band_t             band;
        logic [SHIFT_W-1:0] shift;
        logic [DIV_W-1:0]  divisor;
        logic              status;
    } f1_t;

    typedef struct packed {
        logic               valid;
        logic [NUM_W-1:0]   prod_a;
        logic [NUM_W-1:0]   prod_b;
        logic               sub;
        logic               zero;
        logic [SHIFT_W-1:0] shift;
        logic [DIV_W-1:0]   divisor;
        logic               status;
    } f2_t;

    typedef struct packed {
        logic              valid;
        logic [NUM_W-1:0]  dividend;
        logic [NUM_W-1:0]  quotient;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  divisor;
        logic              status;
    } div_t;

    // integration time in half units
    function automatic logic [HALF_W-1:0] half_time(input logic [CODE_W-1:0] code);
        logic [HALF_W-1:0] t2;
        case (code)
            3'd0:    t2 = 4'd2;
            3'd1:    t2 = 4'd1;
            3'd2:    t2 = 4'd4;
            3'd3:    t2 = 4'd8;
            3'd4:    t2 = 4'd3;
            3'd5:    t2 = 4'd5;
            3'd6:    t2 = 4'd6;
            3'd7:    t2 = 4'd7;
            default: t2 = 4'd2;
        endcase
        return t2;
    endfunction

endpackage

>>> rtl/lxc_front.sv
// ----------------------------------------------------------------------------
// lxc_front
// Three stages ahead of the divider: ratio band and divisor decode, the two
// coefficient products, then the combine and power-of-two gain shift.
// ----------------------------------------------------------------------------
module lxc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lxc_pkg::FRONT_DEPTH-1:0] en,
    input  logic                         in_valid,
    input  logic [lxc_pkg::CNT_W-1:0]    visible_ir_count,
    input  logic [lxc_pkg::CNT_W-1:0]    ir_count,
    input  logic [lxc_pkg::CODE_W-1:0]   gain_code,
    input  logic [lxc_pkg::CODE_W-1:0]   integration_code,
    output logic [lxc_pkg::FRONT_DEPTH-1:0] valid,
    output lxc_pkg::div_t                div_out
);
    import lxc_pkg::*;

    f1_t  f1_reg, f1_next;
    f2_t  f2_reg, f2_next;
    div_t f3_reg, f3_next;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] ch1_scaled;
    logic [PROD_W-1:0] sum_low;
    logic [PROD_W-1:0] sum_mid;
    logic [PROD_W-1:0] sum_high;
    logic [HALF_W-1:0] t2;
    logic [DIV_W-1:0]  base;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [NUM_W-1:0]  num;

    // stage 1: band select by cross-multiplication, divisor decode
    always_comb
    begin
        sum        = SUM_W'(visible_ir_count) + SUM_W'(ir_count);
        ch1_scaled = PROD_W'(ir_count) * PROD_W'(RATIO_SCALE);
        sum_low    = PROD_W'(sum) * PROD_W'(RATIO_LOW);
        sum_mid    = PROD_W'(sum) * PROD_W'(RATIO_MID);
        sum_high   = PROD_W'(sum) * PROD_W'(RATIO_HIGH);
        t2         = half_time(integration_code);
        base       = DIV_W'({t2, 2'b00}) + DIV_W'(t2);

        f1_next.valid  = in_valid;
        f1_next.ch0    = visible_ir_count;
        f1_next.ch1    = ir_count;
        f1_next.status = gain_code inside {GAIN_BAD4, GAIN_BAD5};

        if (sum == '0)
            f1_next.band = BAND_ZERO;
        else if (ch1_scaled < sum_low)
            f1_next.band = BAND_LOW;
        else if (ch1_scaled < sum_mid)
            f1_next.band = BAND_MID;
        else if (ch1_scaled < sum_high)
            f1_next.band = BAND_HIGH;
        else
            f1_next.band = BAND_ZERO;

        // 48 and 96 are 3 * 16 and 3 * 32
        case (gain_code)
            GAIN_X48:
            begin
                f1_next.shift   = 3'd4;
                f1_next.divisor = base + DIV_W'({base, 1'b0});
            end
            GAIN_X96:
            begin
                f1_next.shift   = 3'd5;
                f1_next.divisor = base + DIV_W'({base, 1'b0});
            end
            default:
            begin
                f1_next.shift   = gain_code;
                f1_next.divisor = base;
            end
        endcase
    end

    // stage 2: coefficient products
    always_comb
    begin
        case (f1_reg.band)
            BAND_LOW:
            begin
                coef_a = COEF_LOW_A;
                coef_b = COEF_LOW_B;
            end
            BAND_MID:
            begin
                coef_a = COEF_MID_A;
                coef_b = COEF_MID_B;
            end
            BAND_HIGH:
            begin
                coef_a = COEF_HIGH_A;
                coef_b = COEF_HIGH_B;
            end
            default:
            begin
                coef_a = '0;
                coef_b = '0;
            end
        endcase
        f2_next.valid   = f1_reg.valid;
        f2_next.prod_a  = NUM_W'(coef_a) * NUM_W'(f1_reg.ch0);
        f2_next.prod_b  = NUM_W'(coef_b) * NUM_W'(f1_reg.ch1);
        f2_next.sub     = (f1_reg.band == BAND_MID);
        f2_next.zero    = (f1_reg.band == BAND_ZERO) || f1_reg.status;
        f2_next.shift   = f1_reg.shift;
        f2_next.divisor = f1_reg.divisor;
        f2_next.status  = f1_reg.status;
    end

    // stage 3: combine, clamp the middle formula at zero, gain shift
    always_comb
    begin
        if (f2_reg.zero)
            num = '0;
        else if (!f2_reg.sub)
            num = f2_reg.prod_a + f2_reg.prod_b;
        else if (f2_reg.prod_a > f2_reg.prod_b)
            num = f2_reg.prod_a - f2_reg.prod_b;
        else
            num = '0;

        f3_next.valid    = f2_reg.valid;
        f3_next.dividend = num >> f2_reg.shift;
        f3_next.quotient = '0;
        f3_next.rem      = '0;
        f3_next.divisor  = f2_reg.divisor;
        f3_next.status   = f2_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
        end
        else
        begin
            if (en[0])
                f1_reg <= f1_next;
            if (en[1])
                f2_reg <= f2_next;
            if (en[2])
                f3_reg <= f3_next;
        end
    end

    assign valid   = {f3_reg.valid, f2_reg.valid, f1_reg.valid};
    assign div_out = f3_reg;

endmodule

>>> rtl/lxc_div_step.sv
// ----------------------------------------------------------------------------
// lxc_div_step
// One radix-4 restoring division stage: two quotient bits per beat against
// a divisor of at most seven bits.
// ----------------------------------------------------------------------------
module lxc_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  lxc_pkg::div_t stage_in,
    output lxc_pkg::div_t stage_out
);
    import lxc_pkg::*;

    div_t stage_reg, stage_next;

    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] d1;
    logic [TRIAL_W-1:0] d2;
    logic [TRIAL_W-1:0] d3;
    logic [TRIAL_W-1:0] rem_wide;
    logic [DIGIT_W-1:0] digit;

    always_comb
    begin
        trial = {stage_in.rem, stage_in.dividend[NUM_W-1 -: DIGIT_W]};
        d1    = TRIAL_W'(stage_in.divisor);
        d2    = {d1[TRIAL_W-2:0], 1'b0};
        d3    = d2 + d1;

        if (trial >= d3)
        begin
            digit    = 2'd3;
            rem_wide = trial - d3;
        end
        else if (trial >= d2)
        begin
            digit    = 2'd2;
            rem_wide = trial - d2;
        end
        else if (trial >= d1)
        begin
            digit    = 2'd1;
            rem_wide = trial - d1;
        end
        else
        begin
            digit    = 2'd0;
            rem_wide = trial;
        end

        stage_next          = stage_in;
        stage_next.dividend = {stage_in.dividend[NUM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        stage_next.quotient = {stage_in.quotient[NUM_W-DIGIT_W-1:0], digit};
        stage_next.rem      = rem_wide[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

>>> rtl/two_channel_lux_calculator_unit.sv
// ----------------------------------------------------------------------------
// two_channel_lux_calculator_unit
// Illuminance in milli-lux from two raw light-sensor channel counts.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready, one beat carries visible_ir_count
//   (channel 0) and ir_count (channel 1). output channel: out_valid /
//   out_ready, one beat of lux_milli and status for every input beat, in order.
//   cfg_write with cfg_index 0 sets the gain code, index 1 the integration
//   time code; write only while nothing is in flight.
//   the path from input beat to out_valid runs through three front stages
//   (band decode, coefficient products, combine and gain shift), sixteen
//   radix-4 divider stages and the output register. one beat per cycle is
//   taken and given for as long as the receiver keeps up.
//   gain codes 4 and 5 return status 1 with zero lux.
//   reset clears both config registers to code 0 and empties the pipeline.
//   when the receiver stalls, beats close up behind the held output and
//   in_ready stays high until every stage holds a beat.
// ----------------------------------------------------------------------------
module two_channel_lux_calculator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lxc_pkg::CNT_W-1:0]   visible_ir_count,
    input  logic [lxc_pkg::CNT_W-1:0]   ir_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lxc_pkg::LUX_W-1:0]   lux_milli,
    output logic                        status,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [lxc_pkg::CODE_W-1:0]  cfg_data
);
    import lxc_pkg::*;

    logic [CODE_W-1:0]     gain_code_reg;
    logic [CODE_W-1:0]     integration_code_reg;
    logic [PIPE_DEPTH-1:0] v;
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] bubble;
    div_t                  div_pipe [0:DIV_STEPS];
    logic                  out_valid_reg;
    logic [LUX_W-1:0]      lux_reg;
    logic [LUX_W-1:0]      lux_next;
    logic                  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_code_reg        <= '0;
            integration_code_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GAIN:  gain_code_reg        <= cfg_data;
                CFG_ITIME: integration_code_reg <= cfg_data;
                default:   gain_code_reg        <= gain_code_reg;
            endcase
        end
    end

    // a stage may load when out_ready is high or any stage from it onwards holds a bubble
    always_comb
    begin
        bubble = ~v;
        for (int i = 0; i < PIPE_DEPTH; i++)
            en[i] = out_ready || ((bubble >> i) != '0);
    end

    assign in_ready = en[0];

    lxc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en[FRONT_DEPTH-1:0]),
        .in_valid         (in_valid),
        .visible_ir_count (visible_ir_count),
        .ir_count         (ir_count),
        .gain_code        (gain_code_reg),
        .integration_code (integration_code_reg),
        .valid            (v[FRONT_DEPTH-1:0]),
        .div_out          (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        lxc_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[FRONT_DEPTH + g]),
            .stage_in  (div_pipe[g]),
            .stage_out (div_pipe[g + 1])
        );
        assign v[FRONT_DEPTH + g] = div_pipe[g + 1].valid;
    end

    // saturate the quotient to the result width
    always_comb
    begin
        if (div_pipe[DIV_STEPS].quotient > NUM_W'(LUX_MAX))
            lux_next = LUX_MAX;
        else
            lux_next = div_pipe[DIV_STEPS].quotient[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en[PIPE_DEPTH-1])
            out_valid_reg <= div_pipe[DIV_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en[PIPE_DEPTH-1])
        begin
            lux_reg    <= lux_next;
            status_reg <= div_pipe[DIV_STEPS].status;
        end
    end

    assign v[PIPE_DEPTH-1] = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign lux_milli       = lux_reg;
    assign status          = status_reg;

    // an invalid gain never carries a lux value
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (lux_milli == '0))
        else $error("lux nonzero with invalid gain status");

    // back-pressure only when the output is held and every stage is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && (&v)))
        else $error("input stalled with a bubble in the pipeline");

    // a beat leaving the dividers is never dropped behind a held output
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (div_pipe[DIV_STEPS].valid && out_valid && !out_ready)
            |=> div_pipe[DIV_STEPS].valid)
        else $error("divider beat lost during output stall");

endmodule

>>> tb/two_channel_lux_calculator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_lux_calculator_unit_test
// Drives sample pairs through the lux calculator under a series of gain and
// integration time settings. Every pair is predicted in the testbench and
// each output beat is checked in order. Both sides idle at random. One long
// receiver hold fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module two_channel_lux_calculator_unit_test;

    import lxc_pkg::*;

    // gain and integration time codes not named in the package
    localparam logic [CODE_W-1:0] GAIN_X1   = 3'd0;
    localparam logic [CODE_W-1:0] GAIN_X2   = 3'd1;
    localparam logic [CODE_W-1:0] GAIN_X4   = 3'd2;
    localparam logic [CODE_W-1:0] GAIN_X8   = 3'd3;
    localparam logic [CODE_W-1:0] ITIME_1P0 = 3'd0;
    localparam logic [CODE_W-1:0] ITIME_0P5 = 3'd1;
    localparam logic [CODE_W-1:0] ITIME_2P0 = 3'd2;
    localparam logic [CODE_W-1:0] ITIME_4P0 = 3'd3;
    localparam logic [CODE_W-1:0] ITIME_1P5 = 3'd4;
    localparam logic [CODE_W-1:0] ITIME_2P5 = 3'd5;
    localparam logic [CODE_W-1:0] ITIME_3P0 = 3'd6;
    localparam logic [CODE_W-1:0] ITIME_3P5 = 3'd7;

    // coefficients times 10000, ratio bounds in percent
    localparam logic [63:0] K_LOW_CH0  = 64'd17743;
    localparam logic [63:0] K_LOW_CH1  = 64'd11059;
    localparam logic [63:0] K_MID_CH0  = 64'd42785;
    localparam logic [63:0] K_MID_CH1  = 64'd19548;
    localparam logic [63:0] K_HIGH_CH0 = 64'd5926;
    localparam logic [63:0] K_HIGH_CH1 = 64'd1185;
    localparam int          PCT_FULL   = 100;
    localparam int          PCT_LOW    = 45;
    localparam int          PCT_MID    = 64;
    localparam int          PCT_HIGH   = 85;
    localparam logic [63:0] LUX_LIMIT  = (64'd1 << LUX_W) - 64'd1;

    localparam int NUM_FIXED        = 9;
    localparam int NUM_PHASES       = 13;
    localparam int ITEMS_PER_PHASE  = 50;
    localparam int PRESSURE_PHASE   = 3;
    localparam int HOLD_CYCLES      = 80;
    localparam int DRAIN_CYCLES     = 24;
    localparam int QUIET_LIMIT      = 2000;
    localparam int NUM_DIRECTED     = 13;

    localparam logic [CODE_W-1:0] PHASE_GAIN [NUM_FIXED] = '{
        GAIN_X1, GAIN_X1, GAIN_X96, GAIN_BAD4, GAIN_BAD5,
        GAIN_X8, GAIN_X48, GAIN_X2, GAIN_X4
    };
    localparam logic [CODE_W-1:0] PHASE_ITIME [NUM_FIXED] = '{
        ITIME_1P0, ITIME_0P5, ITIME_4P0, ITIME_2P0, ITIME_3P5,
        ITIME_1P5, ITIME_2P5, ITIME_3P0, ITIME_3P5
    };

    // count extremes, band edges either side, and a low-band pair near full scale
    localparam logic [CNT_W-1:0] DIR_CH0 [NUM_DIRECTED] = '{
        16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd0,
        16'd55, 16'd56, 16'd36, 16'd37, 16'd15, 16'd16, 16'd65535
    };
    localparam logic [CNT_W-1:0] DIR_CH1 [NUM_DIRECTED] = '{
        16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd1,
        16'd45, 16'd45, 16'd64, 16'd64, 16'd85, 16'd85, 16'd53600
    };

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             status;
    } lux_beat_t;

    class lux_scoreboard;
        lux_beat_t         expected_q[$];
        logic [CODE_W-1:0] gain_code;
        logic [CODE_W-1:0] itime_code;
        int unsigned       checked;
        int unsigned       failures;

        function new();
            gain_code  = GAIN_X1;
            itime_code = ITIME_1P0;
            checked    = 0;
            failures   = 0;
        endfunction

        function void set_register(input logic idx, input logic [CODE_W-1:0] value);
            if (idx == CFG_GAIN)
                gain_code = value;
            else
                itime_code = value;
        endfunction

        function lux_beat_t compute_lux(input logic [CNT_W-1:0] ch0,
                                        input logic [CNT_W-1:0] ch1);
            lux_beat_t   r;
            logic [63:0] c0;
            logic [63:0] c1;
            logic [63:0] total;
            logic [63:0] num;
            logic [63:0] quot;
            int unsigned gain;
            int unsigned half_units;
            band_t       band;
            c0    = 64'(ch0);
            c1    = 64'(ch1);
            total = c0 + c1;
            case (gain_code)
                GAIN_X1:  gain = 1;
                GAIN_X2:  gain = 2;
                GAIN_X4:  gain = 4;
                GAIN_X8:  gain = 8;
                GAIN_X48: gain = 48;
                GAIN_X96: gain = 96;
                default:  gain = 0;
            endcase
            case (itime_code)
                ITIME_1P0: half_units = 2;
                ITIME_0P5: half_units = 1;
                ITIME_2P0: half_units = 4;
                ITIME_4P0: half_units = 8;
                ITIME_1P5: half_units = 3;
                ITIME_2P5: half_units = 5;
                ITIME_3P0: half_units = 6;
                default:   half_units = 7;
            endcase
            r.lux    = '0;
            r.status = 1'b0;
            if (gain == 0) begin
                r.status = 1'b1;
                return r;
            end
            if (total == 0)
                band = BAND_ZERO;
            else if (PCT_FULL * c1 < PCT_LOW * total)
                band = BAND_LOW;
            else if (PCT_FULL * c1 < PCT_MID * total)
                band = BAND_MID;
            else if (PCT_FULL * c1 < PCT_HIGH * total)
                band = BAND_HIGH;
            else
                band = BAND_ZERO;
            case (band)
                BAND_LOW:  num = K_LOW_CH0 * c0 + K_LOW_CH1 * c1;
                BAND_MID:  num = (K_MID_CH0 * c0 > K_MID_CH1 * c1) ?
                                 K_MID_CH0 * c0 - K_MID_CH1 * c1 : 64'd0;
                BAND_HIGH: num = K_HIGH_CH0 * c0 + K_HIGH_CH1 * c1;
                default:   num = 64'd0;
            endcase
            quot = num / (64'd5 * gain * half_units);
            if (quot > LUX_LIMIT)
                quot = LUX_LIMIT;
            r.lux = quot[LUX_W-1:0];
            return r;
        endfunction

        function void note_input(input logic [CNT_W-1:0] ch0, input logic [CNT_W-1:0] ch1);
            expected_q.push_back(compute_lux(ch0, ch1));
        endfunction

        function void check_result(input logic [LUX_W-1:0] lux, input logic st);
            lux_beat_t want;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected beat, lux_milli %0d status %0d", $time, lux, st);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (lux !== want.lux) begin
                failures++;
                $display("%0t: lux_milli expected %0d actual %0d", $time, want.lux, lux);
            end
            if (st !== want.status) begin
                failures++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                failures += expected_q.size();
                $display("%0t: %0d results never arrived", $time, expected_q.size());
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CNT_W-1:0]  visible_ir_count;
    logic [CNT_W-1:0]  ir_count;
    logic              out_valid;
    logic              out_ready;
    logic [LUX_W-1:0]  lux_milli;
    logic              status;
    logic              cfg_write;
    logic              cfg_index;
    logic [CODE_W-1:0] cfg_data;

    lux_scoreboard sb = new();
    int          quiet_cycles = 0;
    int unsigned pairs_sent = 0;
    int          send_gap_max = 8;
    int          recv_gap_max = 8;
    bit          hold_request = 1'b0;

    two_channel_lux_calculator_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .visible_ir_count (visible_ir_count),
        .ir_count         (ir_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lux_milli        (lux_milli),
        .status           (status),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // beat monitor
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_input(visible_ir_count, ir_count);
        if (out_valid && out_ready)
            sb.check_result(lux_milli, status);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    // receiver: random stall per beat, one long hold on request
    initial
    begin : receiver
        int stall;
        bit holding;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            holding = hold_request;
            stall   = holding ? HOLD_CYCLES : $urandom_range(0, recv_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            if (holding)
                hold_request = 1'b0;
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_pair(input logic [CNT_W-1:0] c0, input logic [CNT_W-1:0] c1);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        visible_ir_count <= c0;
        ir_count         <= c1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    task automatic write_settings(input logic [CODE_W-1:0] gain_code,
                                  input logic [CODE_W-1:0] itime_code);
        cfg_write <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain_code;
        @(posedge clk);
        cfg_index <= CFG_ITIME;
        cfg_data  <= itime_code;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(CFG_GAIN, gain_code);
        sb.set_register(CFG_ITIME, itime_code);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mix of full-range, small, one-sided, one-channel full-scale and band-edge pairs
    function automatic void draw_pair(output logic [CNT_W-1:0] c0,
                                      output logic [CNT_W-1:0] c1);
        int a;
        int b;
        int pct;
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        case ($urandom_range(0, 5))
            0: ;
            1:
            begin
                a = $urandom_range(0, 15);
                b = $urandom_range(0, 15);
            end
            2:
            begin
                if ($urandom_range(0, 1))
                    a = 0;
                else
                    b = 0;
            end
            5:
            begin
                if ($urandom_range(0, 1))
                    a = 65535;
                else
                    b = 65535;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       pct = PCT_LOW;
                    1:       pct = PCT_MID;
                    default: pct = PCT_HIGH;
                endcase
                a = $urandom_range(1, 9000);
                b = a * pct / (PCT_FULL - pct) + $urandom_range(0, 2) - 1;
                if (b < 0)
                    b = 0;
                if (b > 65535)
                    b = 65535;
            end
        endcase
        c0 = CNT_W'(a);
        c1 = CNT_W'(b);
    endfunction

    initial
    begin : stimulus
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        visible_ir_count <= '0;
        ir_count         <= '0;
        cfg_write        <= 1'b0;
        cfg_index        <= CFG_GAIN;
        cfg_data         <= GAIN_X1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // phase 0 runs on the reset settings
            if (p > 0)
            begin
                wait_drained();
                if (p < NUM_FIXED)
                    write_settings(PHASE_GAIN[p], PHASE_ITIME[p]);
                else
                    write_settings(CODE_W'($urandom_range(0, 7)),
                                   CODE_W'($urandom_range(0, 7)));
            end
            case (p % 3)
                0:
                begin
                    send_gap_max = 8;
                    recv_gap_max = 8;
                end
                1:
                begin
                    send_gap_max = 0;
                    recv_gap_max = 0;
                end
                default:
                begin
                    send_gap_max = $urandom_range(0, 1) ? 8 : 0;
                    recv_gap_max = 8 - send_gap_max;
                end
            endcase
            if (p == PRESSURE_PHASE)
            begin
                send_gap_max = 0;
                hold_request = 1'b1;
            end
            if (p < 2)
                for (int i = 0; i < NUM_DIRECTED; i++)
                    send_pair(DIR_CH0[i], DIR_CH1[i]);
            repeat (ITEMS_PER_PHASE)
            begin
                draw_pair(c0, c1);
                send_pair(c0, c1);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        sb.close_out();
        $display("covered %0d sample pairs over %0d gain and integration settings",
                 pairs_sent, NUM_PHASES);
        $display("%0d beats checked, %0d mismatches", sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> two_channel_lux_calculator_unit.f
rtl/lxc_pkg.sv
rtl/lxc_front.sv
rtl/lxc_div_step.sv
rtl/two_channel_lux_calculator_unit.sv
tb/two_channel_lux_calculator_unit_test.sv
